// ===== design/sdsce_pkg.sv =====
// Shared types and constants for the SD SPI-mode command engine.
// Used by sdsce_step and sd_spi_command_engine_unit; depends on nothing.
package sdsce_pkg;

   // Request opcodes carried in req_tuser.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Result kinds carried in rsp_tuser.
   localparam logic KIND_TX     = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // Sequencer phase codes.
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_DESEL   = 3'd1;
   localparam logic [2:0] PH_READY   = 3'd2;
   localparam logic [2:0] PH_SEND    = 3'd3;
   localparam logic [2:0] PH_DISCARD = 3'd4;
   localparam logic [2:0] PH_RESP    = 3'd5;
   localparam logic [2:0] PH_FAIL    = 3'd6;

   // Command indexes with special handling.
   localparam logic [5:0] IDX_STOP   = 6'd12;
   localparam logic [5:0] IDX_IFCOND = 6'd8;
   localparam logic [5:0] IDX_APP    = 6'd55;

   // Byte constants of the SPI-mode protocol.
   localparam logic [7:0] BYTE_IDLE   = 8'hFF;
   localparam logic [7:0] CMD_START   = 8'h40;
   localparam logic [7:0] CRC_IFCOND  = 8'h87;
   localparam logic [7:0] CRC_DEFAULT = 8'h95;

   // Configuration registers.
   localparam logic       CSR_READY_TIMEOUT  = 1'b0;
   localparam logic       CSR_RESPONSE_POLLS = 1'b1;
   localparam logic [15:0] READY_TIMEOUT_RST  = 16'd500;
   localparam logic [7:0]  RESPONSE_POLLS_RST = 8'd10;

   typedef struct packed {
      logic [2:0]  phase;
      logic [5:0]  command_index;
      logic        app_pending;
      logic [31:0] argument;
      logic [2:0]  byte_count;
      logic [7:0]  poll_count;
      logic [15:0] tick_count;
      logic        timed_out;
      logic        select_low;
   } state_type;

   typedef struct packed {
      logic       valid;
      logic       kind;
      logic [7:0] tx_byte;
      logic       chip_select_low;
      logic [7:0] response;
   } result_type;

endpackage

// ===== design/sdsce_step.sv =====
// Next-state and result logic of the SD SPI-mode command sequencer.
// Purely combinational; depends on sdsce_pkg.
module sdsce_step (
   input  sdsce_pkg::state_type  state,
   input  logic [1:0]            opcode,
   input  logic [7:0]            cmd_code,
   input  logic [31:0]           argument,
   input  logic [7:0]            rx_byte,
   input  logic [15:0]           ready_timeout,
   input  logic [7:0]            response_polls,
   output sdsce_pkg::state_type  next_state,
   output sdsce_pkg::result_type result
);

   logic [5:0]  active_idx;
   logic [5:0]  begin_idx;
   logic [31:0] send_arg;
   logic [7:0]  arg_byte;
   logic [15:0] tick_next;
   logic [7:0]  poll_next;

   assign active_idx = state.app_pending ? sdsce_pkg::IDX_APP : state.command_index;
   assign send_arg   = state.app_pending ? 32'd0 : state.argument;
   assign tick_next  = (state.tick_count < ready_timeout) ? state.tick_count + 16'd1
                                                          : state.tick_count;
   assign poll_next  = (state.poll_count != 8'd0) ? state.poll_count - 8'd1 : 8'd0;

   always_comb begin
      case (state.byte_count[1:0])
         2'd0:    arg_byte = send_arg[31:24];
         2'd1:    arg_byte = send_arg[23:16];
         2'd2:    arg_byte = send_arg[15:8];
         default: arg_byte = send_arg[7:0];
      endcase
   end

   always_comb begin
      next_state = state;
      result     = '0;
      begin_idx  = '0;

      unique case (opcode)
         sdsce_pkg::OP_START: begin
            if (state.phase == sdsce_pkg::PH_IDLE) begin
               next_state.command_index = cmd_code[5:0];
               next_state.argument      = argument;
               next_state.app_pending   = cmd_code[7];
               begin_idx = cmd_code[7] ? sdsce_pkg::IDX_APP : cmd_code[5:0];
               result.valid = 1'b1;
               result.kind  = sdsce_pkg::KIND_TX;
               if (begin_idx == sdsce_pkg::IDX_STOP) begin
                  next_state.phase      = sdsce_pkg::PH_SEND;
                  next_state.byte_count = 3'd0;
                  result.tx_byte        = sdsce_pkg::CMD_START | {2'b00, begin_idx};
               end else begin
                  next_state.select_low = 1'b0;
                  next_state.phase      = sdsce_pkg::PH_DESEL;
                  result.tx_byte        = sdsce_pkg::BYTE_IDLE;
               end
            end
         end
         sdsce_pkg::OP_TICK: begin
            if (state.phase == sdsce_pkg::PH_READY) begin
               next_state.tick_count = tick_next;
               if (tick_next >= ready_timeout) next_state.timed_out = 1'b1;
            end
         end
         sdsce_pkg::OP_BYTE: begin
            result.kind = sdsce_pkg::KIND_TX;
            case (state.phase)
               sdsce_pkg::PH_DESEL: begin
                  next_state.select_low = 1'b1;
                  next_state.tick_count = 16'd0;
                  next_state.timed_out  = 1'b0;
                  next_state.phase      = sdsce_pkg::PH_READY;
                  result.valid          = 1'b1;
                  result.tx_byte        = sdsce_pkg::BYTE_IDLE;
               end
               sdsce_pkg::PH_READY: begin
                  result.valid = 1'b1;
                  if (state.timed_out) begin
                     next_state.select_low = 1'b0;
                     next_state.phase      = sdsce_pkg::PH_FAIL;
                     result.tx_byte        = sdsce_pkg::BYTE_IDLE;
                  end else if (rx_byte == sdsce_pkg::BYTE_IDLE) begin
                     next_state.phase      = sdsce_pkg::PH_SEND;
                     next_state.byte_count = 3'd0;
                     result.tx_byte        = sdsce_pkg::CMD_START | {2'b00, active_idx};
                  end else begin
                     result.tx_byte = sdsce_pkg::BYTE_IDLE;
                  end
               end
               sdsce_pkg::PH_FAIL: begin
                  next_state.phase       = sdsce_pkg::PH_IDLE;
                  next_state.app_pending = 1'b0;
                  result.valid           = 1'b1;
                  result.kind            = sdsce_pkg::KIND_FINISH;
                  result.response        = sdsce_pkg::BYTE_IDLE;
               end
               sdsce_pkg::PH_SEND: begin
                  result.valid = 1'b1;
                  if (state.byte_count < 3'd4) begin
                     next_state.byte_count = state.byte_count + 3'd1;
                     result.tx_byte        = arg_byte;
                  end else if (state.byte_count == 3'd4) begin
                     next_state.byte_count = 3'd5;
                     result.tx_byte = (active_idx == sdsce_pkg::IDX_IFCOND)
                                      ? sdsce_pkg::CRC_IFCOND : sdsce_pkg::CRC_DEFAULT;
                  end else begin
                     next_state.byte_count = 3'd0;
                     next_state.poll_count = (response_polls != 8'd0) ? response_polls
                                                                       : 8'd1;
                     next_state.phase = (active_idx == sdsce_pkg::IDX_STOP)
                                        ? sdsce_pkg::PH_DISCARD : sdsce_pkg::PH_RESP;
                     result.tx_byte   = sdsce_pkg::BYTE_IDLE;
                  end
               end
               sdsce_pkg::PH_DISCARD: begin
                  next_state.phase = sdsce_pkg::PH_RESP;
                  result.valid     = 1'b1;
                  result.tx_byte   = sdsce_pkg::BYTE_IDLE;
               end
               sdsce_pkg::PH_RESP: begin
                  next_state.poll_count = poll_next;
                  result.valid          = 1'b1;
                  if (rx_byte[7] && poll_next != 8'd0) begin
                     result.tx_byte = sdsce_pkg::BYTE_IDLE;
                  end else if (state.app_pending && rx_byte <= 8'd1) begin
                     // CMD55 accepted: launch the real command.
                     next_state.app_pending = 1'b0;
                     begin_idx = state.command_index;
                     if (begin_idx == sdsce_pkg::IDX_STOP) begin
                        next_state.phase      = sdsce_pkg::PH_SEND;
                        next_state.byte_count = 3'd0;
                        result.tx_byte = sdsce_pkg::CMD_START | {2'b00, begin_idx};
                     end else begin
                        next_state.select_low = 1'b0;
                        next_state.phase      = sdsce_pkg::PH_DESEL;
                        result.tx_byte        = sdsce_pkg::BYTE_IDLE;
                     end
                  end else begin
                     next_state.phase       = sdsce_pkg::PH_IDLE;
                     next_state.app_pending = 1'b0;
                     result.kind            = sdsce_pkg::KIND_FINISH;
                     result.response = state.app_pending ? sdsce_pkg::BYTE_IDLE : rx_byte;
                  end
               end
               default: begin
                  result.valid = 1'b0;
               end
            endcase
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase

      result.chip_select_low = next_state.select_low;
   end

endmodule

// ===== design/sd_spi_command_engine_unit.sv =====
// SD SPI-mode command engine: the result of an accepted request is registered in the output
// register at the next clock edge; throughput one request per cycle while the output register
// is empty or being drained, set by the single state update in sdsce_step. A request may be
// accepted in the same cycle that a waiting result is taken. Reset is synchronous and active
// high: it returns the sequencer to idle with chip select released and loads the timeout
// (500 ticks) and poll (10 bytes) defaults. Depends on sdsce_pkg and sdsce_step.
module sd_spi_command_engine_unit (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // cmd_code[7:0], argument[39:8], rx_byte[47:40]
   input  logic [1:0]  req_tuser,   // opcode
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // tx_byte[7:0], chip_select_low[8], response[16:9], zeros
   output logic        rsp_tuser,   // kind
   // Configuration write port.
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   sdsce_pkg::state_type  state_ff, state_in;
   sdsce_pkg::result_type step_result;
   logic [15:0] ready_timeout_ff;
   logic [7:0]  response_polls_ff;
   logic        out_valid_ff;
   logic        out_kind_ff;
   logic [7:0]  out_tx_ff;
   logic        out_csl_ff;
   logic [7:0]  out_resp_ff;
   logic        accept;

   // The output register can take a new result when it is empty or being drained.
   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   sdsce_step u_step (
      .state          (state_ff),
      .opcode         (req_tuser),
      .cmd_code       (req_tdata[7:0]),
      .argument       (req_tdata[39:8]),
      .rx_byte        (req_tdata[47:40]),
      .ready_timeout  (ready_timeout_ff),
      .response_polls (response_polls_ff),
      .next_state     (state_in),
      .result         (step_result)
   );

   // Configuration registers. Writes must arrive only while the engine is idle; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_timeout_ff  <= sdsce_pkg::READY_TIMEOUT_RST;
         response_polls_ff <= sdsce_pkg::RESPONSE_POLLS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            sdsce_pkg::CSR_READY_TIMEOUT:  ready_timeout_ff  <= csr_wdata;
            sdsce_pkg::CSR_RESPONSE_POLLS: response_polls_ff <= csr_wdata[7:0];
            default:                       ready_timeout_ff  <= ready_timeout_ff;
         endcase
      end
   end

   // Sequencer state moves only when a request is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Output register: the valid flag is control; the payload just follows it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= step_result.valid;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_result.valid) begin
         out_kind_ff <= step_result.kind;
         out_tx_ff   <= step_result.tx_byte;
         out_csl_ff  <= step_result.chip_select_low;
         out_resp_ff <= step_result.response;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {7'd0, out_resp_ff, out_csl_ff, out_tx_ff};

   // A finished command leaves the sequencer idle until the result is taken.
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == sdsce_pkg::KIND_FINISH) |->
         (state_ff.phase == sdsce_pkg::PH_IDLE))
      else $error("finish result present while sequencer busy");

   // A stalled result blocks all state movement.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(state_ff))
      else $error("sequencer state moved during output stall");

   // While collecting R1 there is always at least one poll left.
   a_resp_polls: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == sdsce_pkg::PH_RESP) |-> (state_ff.poll_count != 8'd0))
      else $error("response phase with empty poll budget");

endmodule
